/* src/ascz_pkg.sv */
`default_nettype none

package ascz_pkg;

	// Fixed point format of stick samples and magnitudes.
	localparam int FRAC_BITS = 14;
	localparam logic [14:0] ONE_Q = 15'(1 << FRAC_BITS);

	// Iteration counts of the shared square root / CORDIC loop and the divider.
	localparam int ITER_STEPS = 16;
	localparam int DIV_STEPS = FRAC_BITS + 1;

	// Angle constants in units of 1/64 degree, and the CORDIC clamp in 1/4096 degree.
	localparam logic [14:0] DEG_90 = 15'd5760;
	localparam logic [14:0] DEG_180 = 15'd11520;
	localparam logic [14:0] DEG_360 = 15'd23040;
	localparam logic [18:0] Z_MAX = 19'd368640;

	// Reset values of the zone markers.
	localparam logic [14:0] MARKER_RST_0 = 15'd1966;
	localparam logic [14:0] MARKER_RST_1 = 15'd3277;
	localparam logic [14:0] MARKER_RST_2 = 15'd8192;
	localparam logic [14:0] MARKER_RST_3 = 15'd12288;
	localparam logic [14:0] MARKER_RST_4 = 15'd16384;

	// Configuration register indexes.
	localparam logic [2:0] CFG_LOCK = 3'd0;
	localparam logic [2:0] CFG_MARK0 = 3'd1;
	localparam logic [2:0] CFG_MARK1 = 3'd2;
	localparam logic [2:0] CFG_MARK2 = 3'd3;
	localparam logic [2:0] CFG_MARK3 = 3'd4;
	localparam logic [2:0] CFG_MARK4 = 3'd5;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ITER,
		ST_ZONE,
		ST_DIV,
		ST_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sq_x;
		logic sq_y;
		logic iter;
		logic zone;
		logic div;
		logic commit;
		logic [3:0] step;
	} dp_cmd_t;

	// CORDIC arctangent table in units of 1/4096 degree.
	function automatic logic [18:0] atan_entry(input logic [3:0] idx);
		logic [18:0] v;
		case (idx)
			4'd0: v = 19'd184320;
			4'd1: v = 19'd108810;
			4'd2: v = 19'd57492;
			4'd3: v = 19'd29184;
			4'd4: v = 19'd14649;
			4'd5: v = 19'd7331;
			4'd6: v = 19'd3667;
			4'd7: v = 19'd1833;
			4'd8: v = 19'd917;
			4'd9: v = 19'd458;
			4'd10: v = 19'd229;
			4'd11: v = 19'd115;
			4'd12: v = 19'd57;
			4'd13: v = 19'd29;
			4'd14: v = 19'd14;
			4'd15: v = 19'd7;
			default: v = 19'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* src/ascz_ctrl.sv */
`default_nettype none

module ascz_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic out_stall,
	output logic in_stall,
	output logic out_valid,
	output ascz_pkg::dp_cmd_t cmd
);
	import ascz_pkg::*;

	state_t state_q, state_d;
	logic [3:0] step_q, step_d;
	logic out_valid_q, out_valid_d;

	// State, step counter and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		cmd = '0;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_d = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				step_d = step_q + 4'd1;
				if (step_q == 4'(ITER_STEPS - 1)) begin
					step_d = '0;
					state_d = ST_ZONE;
				end
			end
			ST_ZONE: begin
				cmd.zone = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				step_d = step_q + 4'd1;
				if (step_q == 4'(DIV_STEPS - 1)) begin
					step_d = '0;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// Load the output register once the previous transaction has left.
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The output register holds until the consumer takes it.
	always_comb begin
		if (cmd.commit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* src/ascz_dp.sv */
`default_nettype none

module ascz_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire ascz_pkg::dp_cmd_t cmd,
	input wire logic signed [15:0] stick_x,
	input wire logic signed [15:0] stick_y,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [14:0] cfg_data,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [14:0] magnitude,
	output logic [14:0] heading,
	output logic [2:0] zone_index,
	output logic [14:0] zone_fraction,
	output logic [15:0] active_count,
	output logic [15:0] centered_count,
	output logic newly_active,
	output logic newly_centered
);
	import ascz_pkg::*;

	// Configuration registers.
	logic lock_q;
	logic [14:0] marker_q [5];

	// Sample and working registers.
	logic signed [15:0] x_q, y_q;
	logic [16:0] ax_q, ay_q;
	logic [31:0] sq_q;
	logic [31:0] n_q, r_q, b_q;
	logic signed [26:0] cx_q, cy_q;
	logic signed [20:0] z_q;
	logic [14:0] mag_q, head_q;
	logic zero_zone_q, found_q;
	logic [2:0] zsel_q;
	logic [15:0] rem_q;
	logic [14:0] d_q, quot_q;

	// Persistent state.
	logic [14:0] last_heading_q, last_fraction_q;
	logic [2:0] last_zone_q;
	logic [15:0] active_run_q, centered_run_q;

	// Output register payload.
	logic signed [15:0] out_x_q, out_y_q;
	logic [14:0] out_mag_q, out_head_q, out_frac_q;
	logic [2:0] out_zone_q;
	logic [15:0] out_act_q, out_cen_q;

	logic signed [15:0] lx, ly;
	logic [16:0] ax_c, ay_c;
	logic [33:0] sqx_c, sqy_c;
	logic [32:0] trial;
	logic root_ge;
	logic signed [26:0] dx, dy;
	logic signed [20:0] ang;
	logic [15:0] root;
	logic [14:0] mag_c;
	logic [18:0] zc;
	logic [19:0] zr;
	logic [14:0] phi, th1, th2, th3;
	logic zero_zone_c, found_c;
	logic [2:0] zsel_c;
	logic [14:0] lo_c, hi_c;
	logic div_ge;
	logic [15:0] rtmp;
	logic nonzero;
	logic [14:0] heading_n, fraction_n;
	logic [2:0] zone_n;
	logic [15:0] active_n, centered_n;

	// Register writes from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			marker_q[0] <= MARKER_RST_0;
			marker_q[1] <= MARKER_RST_1;
			marker_q[2] <= MARKER_RST_2;
			marker_q[3] <= MARKER_RST_3;
			marker_q[4] <= MARKER_RST_4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCK: lock_q <= cfg_data[0];
				CFG_MARK0: marker_q[0] <= cfg_data;
				CFG_MARK1: marker_q[1] <= cfg_data;
				CFG_MARK2: marker_q[2] <= cfg_data;
				CFG_MARK3: marker_q[3] <= cfg_data;
				CFG_MARK4: marker_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Apply the lock and take absolute values.
	always_comb begin
		lx = lock_q ? 16'sd0 : stick_x;
		ly = lock_q ? 16'sd0 : stick_y;
		ax_c = lx[15] ? 17'(~{lx[15], lx} + 17'd1) : {1'b0, lx};
		ay_c = ly[15] ? 17'(~{ly[15], ly} + 17'd1) : {1'b0, ly};
	end

	// Squares, one multiplication per cycle.
	assign sqx_c = ax_q * ax_q;
	assign sqy_c = ay_q * ay_q;

	// One step of the digit-by-digit square root.
	assign trial = {1'b0, r_q} + {1'b0, b_q};
	assign root_ge = ({1'b0, n_q} >= trial);

	// One CORDIC vectoring step, run alongside the square root.
	assign dx = cy_q >>> cmd.step;
	assign dy = cx_q >>> cmd.step;
	assign ang = {2'b00, atan_entry(cmd.step)};

	// Clamp the magnitude and round the angle to 1/64 degree.
	always_comb begin
		root = r_q[15:0];
		mag_c = (root > {1'b0, ONE_Q}) ? ONE_Q : root[14:0];
		if (z_q < 0) begin
			zc = '0;
		end else if (z_q > $signed({2'b00, Z_MAX})) begin
			zc = Z_MAX;
		end else begin
			zc = z_q[18:0];
		end
		zr = {1'b0, zc} + 20'd32;
		if (ax_q == '0) begin
			phi = '0;
		end else if (ay_q == '0) begin
			phi = DEG_90;
		end else begin
			phi = {2'b00, zr[18:6]};
		end
		// Quadrant folds.
		th1 = y_q[15] ? DEG_180 - phi : phi;
		th2 = x_q[15] ? DEG_180 - th1 : th1;
		th3 = y_q[15] ? DEG_360 - th2 : th2;
	end

	// Zone search: the lowest zone whose bounds hold the magnitude wins.
	always_comb begin
		zero_zone_c = (mag_c <= marker_q[0]);
		found_c = 1'b0;
		zsel_c = '0;
		lo_c = '0;
		hi_c = '0;
		for (int k = 4; k >= 1; k--) begin
			if (marker_q[k - 1] < mag_c && mag_c <= marker_q[k]) begin
				found_c = 1'b1;
				zsel_c = 3'(k);
				lo_c = marker_q[k - 1];
				hi_c = marker_q[k];
			end
		end
	end

	// One restoring division step, one quotient bit per cycle.
	assign div_ge = (rem_q >= {1'b0, d_q});
	assign rtmp = div_ge ? rem_q - {1'b0, d_q} : rem_q;

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= lx;
			y_q <= ly;
			ax_q <= ax_c;
			ay_q <= ay_c;
		end
		if (cmd.sq_x) begin
			sq_q <= sqx_c[31:0];
		end
		if (cmd.sq_y) begin
			n_q <= sq_q + sqy_c[31:0];
			r_q <= '0;
			b_q <= 32'h4000_0000;
			cx_q <= $signed({2'b00, ay_q, 8'd0});
			cy_q <= $signed({2'b00, ax_q, 8'd0});
			z_q <= '0;
		end
		if (cmd.iter) begin
			if (root_ge) begin
				n_q <= n_q - trial[31:0];
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q <= z_q + ang;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q <= z_q - ang;
			end
		end
		if (cmd.zone) begin
			mag_q <= mag_c;
			head_q <= th3;
			zero_zone_q <= zero_zone_c;
			found_q <= found_c;
			zsel_q <= zsel_c;
			rem_q <= {1'b0, mag_c - lo_c};
			d_q <= hi_c - lo_c;
			quot_q <= '0;
		end
		if (cmd.div) begin
			rem_q <= {rtmp[14:0], 1'b0};
			quot_q <= {quot_q[13:0], div_ge};
		end
	end

	// Next values of the persistent state for this sample.
	always_comb begin
		nonzero = (ax_q != '0) || (ay_q != '0);
		heading_n = last_heading_q;
		active_n = '0;
		centered_n = '0;
		if (nonzero) begin
			heading_n = head_q;
			active_n = (active_run_q == 16'hFFFF) ? active_run_q : active_run_q + 16'd1;
		end else begin
			centered_n = (centered_run_q == 16'hFFFF) ? centered_run_q
				: centered_run_q + 16'd1;
		end
		zone_n = last_zone_q;
		fraction_n = last_fraction_q;
		if (zero_zone_q) begin
			zone_n = '0;
			fraction_n = '0;
		end else if (found_q) begin
			zone_n = zsel_q;
			fraction_n = quot_q;
		end
	end

	// Persistent state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_heading_q <= '0;
			last_zone_q <= '0;
			last_fraction_q <= '0;
			active_run_q <= '0;
			centered_run_q <= '0;
		end else if (cmd.commit) begin
			last_heading_q <= heading_n;
			last_zone_q <= zone_n;
			last_fraction_q <= fraction_n;
			active_run_q <= active_n;
			centered_run_q <= centered_n;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_x_q <= x_q;
			out_y_q <= y_q;
			out_mag_q <= mag_q;
			out_head_q <= heading_n;
			out_zone_q <= zone_n;
			out_frac_q <= fraction_n;
			out_act_q <= active_n;
			out_cen_q <= centered_n;
		end
	end

	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign magnitude = out_mag_q;
	assign heading = out_head_q;
	assign zone_index = out_zone_q;
	assign zone_fraction = out_frac_q;
	assign active_count = out_act_q;
	assign centered_count = out_cen_q;
	assign newly_active = (out_act_q == 16'd1);
	assign newly_centered = (out_cen_q == 16'd1);

endmodule

`default_nettype wire

/* src/analog_stick_zone_classifier.sv */
// An accepted sample goes through the squares, the 16-step square root / CORDIC loop, the
// zone search and the 15-step restoring divider, one after the other; its result is then
// loaded into the output register, and in_stall stays high until that load is done.
// A result may wait in the output register while the next sample is taken in.
// Reset is asynchronous, active low: it clears the controller, the run counters, the
// held heading and zone, and loads the marker registers with their default values.
`default_nettype none

module analog_stick_zone_classifier (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [15:0] stick_x,
	input wire logic signed [15:0] stick_y,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [14:0] magnitude,
	output logic [14:0] heading,
	output logic [2:0] zone_index,
	output logic [14:0] zone_fraction,
	output logic [15:0] active_count,
	output logic [15:0] centered_count,
	output logic newly_active,
	output logic newly_centered,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [14:0] cfg_data
);
	import ascz_pkg::*;

	dp_cmd_t cmd;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	ascz_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.out_stall(out_stall),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.cmd(cmd)
	);

	ascz_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stick_x(stick_x),
		.stick_y(stick_y),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_x(out_x),
		.out_y(out_y),
		.magnitude(magnitude),
		.heading(heading),
		.zone_index(zone_index),
		.zone_fraction(zone_fraction),
		.active_count(active_count),
		.centered_count(centered_count),
		.newly_active(newly_active),
		.newly_centered(newly_centered)
	);

endmodule

`default_nettype wire

/* src/ascz_chk.sv */
`default_nettype none

module ascz_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [14:0] magnitude,
	input wire logic [14:0] heading,
	input wire logic [2:0] zone_index,
	input wire logic [15:0] active_count,
	input wire logic [15:0] centered_count
);

	// A stalled result stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(magnitude) && $stable(heading)
			&& $stable(zone_index))
		else $error("stalled result changed");

	// After a transaction is taken the block is busy with it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second sample taken while busy");

	// Fields stay in range and the two runs never count at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zone_index <= 3'd4 && magnitude <= 15'd16384
			&& heading <= 15'd23040 && (active_count == 16'd0 || centered_count == 16'd0))
		else $error("result out of range");

endmodule

bind analog_stick_zone_classifier ascz_chk u_ascz_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.magnitude(magnitude),
	.heading(heading),
	.zone_index(zone_index),
	.active_count(active_count),
	.centered_count(centered_count)
);

`default_nettype wire
